@@ design/mcfd_pkg.sv @@
package mcfd_pkg;

    // Field widths
    localparam int ACTION_W   = 1;
    localparam int BYTE_W     = 8;
    localparam int CHAN_OUT_W = 3;
    localparam int DUTY_W     = 14;
    localparam int TIMEOUT_W  = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEADER  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TIMEOUT = 8'd1;

    // Configuration reset values
    localparam logic [BYTE_W-1:0]    HEADER_RESET  = 8'd115;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd200;

    // Input action codes
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // Result cause codes
    localparam logic CAUSE_FRAME    = 1'b0;
    localparam logic CAUSE_FAILSAFE = 1'b1;

    // Code mapping bounds
    localparam logic [BYTE_W-1:0] CODE_MIN  = 8'd50;
    localparam logic [BYTE_W-1:0] CODE_MAX  = 8'd251;
    localparam logic [BYTE_W-1:0] CODE_FWD  = 8'd151;
    localparam logic [BYTE_W-1:0] CODE_REV  = 8'd50;
    localparam logic [DUTY_W-1:0] DUTY_STEP = 14'd100;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;  // consume the input request
        logic start;   // open a run of channel results
        logic emit;    // load the next channel result
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic run_req;    // current input request opens a run
        logic chan_last;  // channel counter is at the final channel
    } t_dp_status;

endpackage

@@ design/mcfd_in_if.sv @@
interface mcfd_in_if import mcfd_pkg::*; ;
    logic              valid;
    logic              ready;
    logic [ACTION_W-1:0] action;
    logic [BYTE_W-1:0] byte_value;

    modport source (output valid, output action, output byte_value, input ready);
    modport sink   (input valid, input action, input byte_value, output ready);
endinterface

@@ design/mcfd_out_if.sv @@
interface mcfd_out_if import mcfd_pkg::*; ;
    logic                  valid;
    logic                  ready;
    logic [CHAN_OUT_W-1:0] channel;
    logic [DUTY_W-1:0]     duty;
    logic                  direction;
    logic                  cause;
    logic                  last;

    modport source (output valid, output channel, output duty, output direction,
                    output cause, output last, input ready);
    modport sink   (input valid, input channel, input duty, input direction,
                    input cause, input last, output ready);
endinterface

@@ design/mcfd_cfg_if.sv @@
interface mcfd_cfg_if import mcfd_pkg::*; ;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/mcfd_ctrl.sv @@
module mcfd_ctrl import mcfd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EMIT = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;
    logic   w_out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.accept = w_accept;
        case (r_state)
            S_IDLE: begin
                if (w_accept && i_status.run_req) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    if (i_status.chan_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ design/mcfd_datapath.sv @@
module mcfd_datapath import mcfd_pkg::*; #(
    parameter int CHANNELS    = 6,
    parameter int FRAME_BYTES = 7
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    input  logic [ACTION_W-1:0]   i_action,
    input  logic [BYTE_W-1:0]     i_byte_value,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic [CHAN_OUT_W-1:0] o_channel,
    output logic [DUTY_W-1:0]     o_duty,
    output logic                  o_direction,
    output logic                  o_cause,
    output logic                  o_last
);

    localparam int CODES = FRAME_BYTES - 1;
    localparam int BR_W  = $clog2(FRAME_BYTES);
    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [BR_W-1:0] BR_LAST  = BR_W'(FRAME_BYTES - 1);
    localparam logic [CH_W-1:0] CH_LAST  = CH_W'(CHANNELS - 1);

    // Configuration registers
    logic [BYTE_W-1:0]    r_header_byte;
    logic [TIMEOUT_W-1:0] r_timeout_ticks;

    // Frame gathering
    logic [BR_W-1:0]   r_br;
    logic [BYTE_W-1:0] r_frame_header;
    logic [BYTE_W-1:0] r_frame_codes [CODES];

    // Channel stores
    logic [DUTY_W-1:0] r_duty_store [CHANNELS];
    logic              r_dir_store  [CHANNELS];

    // Failsafe countdown
    logic                 r_wd_armed;
    logic [TIMEOUT_W-1:0] r_wd_left;
    logic [TIMEOUT_W-1:0] w_left_dec;

    // Run control
    logic [CH_W-1:0] r_chan;
    logic            r_cause;
    logic            r_apply;

    // Output register
    logic [CHAN_OUT_W-1:0] r_out_channel;
    logic [DUTY_W-1:0]     r_out_duty;
    logic                  r_out_dir;
    logic                  r_out_cause;
    logic                  r_out_last;

    logic [BYTE_W-1:0] w_chan_code [CHANNELS];
    logic [BYTE_W-1:0] w_code;
    logic [BYTE_W-1:0] w_off;
    logic [DUTY_W-1:0] w_dec_duty;
    logic              w_dec_dir;
    logic              w_in_range;
    logic [7:0]        w_chan_ext;

    assign w_left_dec = (r_wd_left != '0) ? r_wd_left - 1'b1 : r_wd_left;

    // Status to controller
    assign o_status.run_req   = (i_action == ACT_BYTE) ? (r_br == BR_LAST)
                                                       : (r_wd_armed && w_left_dec == '0);
    assign o_status.chan_last = (r_chan == CH_LAST);

    // Code for each channel; channels past the frame read as code zero
    for (genvar g = 0; g < CHANNELS; g++) begin : g_chan_code
        if (g < CODES) begin : g_byte
            assign w_chan_code[g] = r_frame_codes[g];
        end else begin : g_none
            assign w_chan_code[g] = '0;
        end
    end

    assign w_code = w_chan_code[r_chan];

    // Code to duty and direction
    always_comb begin
        w_in_range = (w_code >= CODE_MIN) && (w_code <= CODE_MAX);
        w_dec_dir  = w_in_range && (w_code >= CODE_FWD);
        w_off      = w_dec_dir ? (w_code - CODE_FWD) : (w_code - CODE_REV);
        w_dec_duty = w_in_range ? (DUTY_W'(w_off) * DUTY_STEP) : '0;
    end

    assign w_chan_ext = {{(8 - CH_W){1'b0}}, r_chan};

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_byte   <= HEADER_RESET;
            r_timeout_ticks <= TIMEOUT_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_IDX_HEADER) begin
                r_header_byte <= i_cfg_data[BYTE_W-1:0];
            end else if (i_cfg_index == CFG_IDX_TIMEOUT) begin
                r_timeout_ticks <= i_cfg_data[TIMEOUT_W-1:0];
            end
        end
    end

    // Byte capture, no reset on payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_action == ACT_BYTE) begin
            if (r_br == '0) begin
                r_frame_header <= i_byte_value;
            end
            for (int i = 0; i < CODES; i++) begin
                if (r_br == BR_W'(i + 1)) begin
                    r_frame_codes[i] <= i_byte_value;
                end
            end
        end
    end

    // Byte count and failsafe countdown
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_br       <= '0;
            r_wd_armed <= 1'b0;
            r_wd_left  <= '0;
        end else if (i_cmd.accept) begin
            if (i_action == ACT_BYTE) begin
                if (r_br == BR_LAST) begin
                    r_br       <= '0;
                    r_wd_armed <= 1'b1;
                    r_wd_left  <= (r_timeout_ticks == '0) ? TIMEOUT_W'(1) : r_timeout_ticks;
                end else begin
                    r_br <= r_br + 1'b1;
                end
            end else if (r_wd_armed) begin
                r_wd_left <= w_left_dec;
                if (w_left_dec == '0) begin
                    r_wd_armed <= 1'b0;
                end
            end
        end
    end

    // Run setup
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_cause <= (i_action == ACT_TICK) ? CAUSE_FAILSAFE : CAUSE_FRAME;
            r_apply <= (r_frame_header == r_header_byte);
        end
    end

    // Channel counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan <= '0;
        end else if (i_cmd.start) begin
            r_chan <= '0;
        end else if (i_cmd.emit) begin
            r_chan <= (r_chan == CH_LAST) ? '0 : r_chan + 1'b1;
        end
    end

    // Stored duty and direction, updated by an applied frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_duty_store[i] <= '0;
                r_dir_store[i]  <= 1'b0;
            end
        end else if (i_cmd.emit && r_cause == CAUSE_FRAME && r_apply) begin
            for (int i = 0; i < CHANNELS; i++) begin
                if (r_chan == CH_W'(i)) begin
                    r_duty_store[i] <= w_dec_duty;
                    r_dir_store[i]  <= w_dec_dir;
                end
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_channel <= w_chan_ext[CHAN_OUT_W-1:0];
            r_out_cause   <= r_cause;
            r_out_last    <= (r_chan == CH_LAST);
            if (r_cause == CAUSE_FAILSAFE) begin
                r_out_duty <= '0;
                r_out_dir  <= 1'b0;
            end else if (r_apply) begin
                r_out_duty <= w_dec_duty;
                r_out_dir  <= w_dec_dir;
            end else begin
                r_out_duty <= r_duty_store[r_chan];
                r_out_dir  <= r_dir_store[r_chan];
            end
        end
    end

    assign o_channel   = r_out_channel;
    assign o_duty      = r_out_duty;
    assign o_direction = r_out_dir;
    assign o_cause     = r_out_cause;
    assign o_last      = r_out_last;

endmodule

@@ design/motor_command_frame_decoder_unit.sv @@
// Channel  Dir  Content
// i_in     in   action (byte or tick), byte_value
// o_out    out  channel, duty, direction, cause, last
// i_cfg    in   index (0 header_byte, 1 timeout_ticks), data
//
// Each input request is taken while the controller is idle.
// A completed frame or a failsafe expiry starts a run of CHANNELS results,
// one per cycle from the channel counter when the sink keeps up;
// input is held off for the length of the run.
// A stalled sink holds the result register and the counter.
// Reset is synchronous active low; the config port is always ready.
module motor_command_frame_decoder_unit import mcfd_pkg::*; #(
    parameter int CHANNELS    = 6,
    parameter int FRAME_BYTES = 7
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    mcfd_in_if.sink    i_in,
    mcfd_out_if.source o_out,
    mcfd_cfg_if.sink   i_cfg
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    assign i_cfg.ready = 1'b1;

    mcfd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    mcfd_datapath #(
        .CHANNELS    (CHANNELS),
        .FRAME_BYTES (FRAME_BYTES)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_action     (i_in.action),
        .i_byte_value (i_in.byte_value),
        .i_cfg_valid  (i_cfg.valid),
        .i_cfg_index  (i_cfg.index),
        .i_cfg_data   (i_cfg.data),
        .o_channel    (o_out.channel),
        .o_duty       (o_out.duty),
        .o_direction  (o_out.direction),
        .o_cause      (o_out.cause),
        .o_last       (o_out.last)
    );

endmodule
